FILE: hw/rtl/asvg_pkg.sv
// Package for the annulus sector vertex generator.
// Holds the shared widths, register codes, stage tags and the CORDIC arctangent table.
// No dependencies.
package asvg_pkg;

  localparam int K_W     = 9;   // slice angle index, up to 256
  localparam int SPAN_W  = 17;  // magnitude of end - start
  localparam int DVD_W   = 25;  // k * |span| fits below 2^25
  localparam int DIV_W   = 9;   // effective slice count, 1..256
  localparam int PH_W    = 16;  // phase, 65536 per turn
  localparam int ANG_W   = 34;  // CORDIC residual angle, 2^-32 turn
  localparam int TRIG_W  = 33;  // cosine and sine, Q1.30 with headroom
  localparam int RAD_W   = 16;
  localparam int COORD_W = 17;
  localparam int CFG_W   = 17;
  localparam int CIDX_W  = 3;
  localparam int ATAN_LEN = 24;

  localparam logic signed [TRIG_W-1:0] INV_GAIN = TRIG_W'(652032874);

  typedef enum logic [CIDX_W-1:0] {
    REG_SUBDIV = 3'd0,
    REG_OUTER  = 3'd1,
    REG_INNER  = 3'd2,
    REG_START  = 3'd3,
    REG_END    = 3'd4
  } cfg_reg_t;

  // Travels alongside every stage: valid, and whether this is the second angle.
  typedef struct packed {
    logic valid;
    logic second;
  } tag_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic signed [COORD_W-1:0] ix;
    logic signed [COORD_W-1:0] iy;
  } coord_set_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/asvg_angle.sv
// Slice angle pipeline: k * span, a one-bit-per-stage restoring divider by the
// slice count, then the start offset and wrap to one turn. Depends on asvg_pkg.
module asvg_angle #(
  parameter int MAX_SLICES = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  asvg_pkg::tag_t                 in_tag,
  input  logic [asvg_pkg::K_W-1:0]       in_k,
  input  logic [8:0]                     subdiv,
  input  logic [asvg_pkg::CFG_W-1:0]     start_ang,
  input  logic [asvg_pkg::CFG_W-1:0]     end_ang,
  output asvg_pkg::tag_t                 out_tag,
  output logic [asvg_pkg::PH_W-1:0]      out_phase
);
  import asvg_pkg::*;

  localparam int CMP_W = 13;

  logic              neg;
  logic [SPAN_W-1:0] span_mag;
  logic [DIV_W-1:0]  divisor;
  logic [K_W+SPAN_W-1:0] prod;

  assign neg      = end_ang < start_ang;
  assign span_mag = neg ? (start_ang - end_ang) : (end_ang - start_ang);
  assign prod     = in_k * span_mag;

  always_comb begin
    if (subdiv == 9'd0) begin
      divisor = DIV_W'(1);
    end else if ({4'd0, subdiv} > CMP_W'(MAX_SLICES)) begin
      divisor = DIV_W'(MAX_SLICES);
    end else begin
      divisor = subdiv;
    end
  end

  // Stage 0 holds the dividend; stage i+1 holds the word after i+1 quotient bits.
  tag_t             tag_r  [DVD_W+1];
  logic [DVD_W-1:0] word_r [DVD_W+1];
  logic [DIV_W-1:0] rem_r  [DVD_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else begin
      tag_r[0] <= in_tag;
    end
    word_r[0] <= prod[DVD_W-1:0];
    rem_r[0]  <= '0;
  end

  for (genvar i = 0; i < DVD_W; i++) begin : g_div
    logic [DIV_W:0] trial;
    logic           take;
    assign trial = {rem_r[i], word_r[i][DVD_W-1]};
    assign take  = trial >= {1'b0, divisor};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[i+1] <= '0;
      end else begin
        tag_r[i+1] <= tag_r[i];
      end
      rem_r[i+1]  <= take ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
      word_r[i+1] <= {word_r[i][DVD_W-2:0], take};
    end
  end

  logic [PH_W-1:0] q_lo;
  logic [PH_W-1:0] phase_r;
  tag_t            ptag_r;

  assign q_lo = word_r[DVD_W][PH_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptag_r <= '0;
    end else begin
      ptag_r <= tag_r[DVD_W];
    end
    phase_r <= start_ang[PH_W-1:0] + (neg ? (~q_lo + PH_W'(1)) : q_lo);
  end

  assign out_tag   = ptag_r;
  assign out_phase = phase_r;

endmodule

FILE: hw/rtl/asvg_cordic.sv
// Rotation-mode CORDIC: quadrant fold, one register stage per iteration, and
// the final sign flip. Depends on asvg_pkg.
module asvg_cordic #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  asvg_pkg::tag_t                     in_tag,
  input  logic [asvg_pkg::PH_W-1:0]          in_phase,
  output asvg_pkg::tag_t                     out_tag,
  output logic signed [asvg_pkg::TRIG_W-1:0] out_cos,
  output logic signed [asvg_pkg::TRIG_W-1:0] out_sin
);
  import asvg_pkg::*;

  localparam logic signed [ANG_W-1:0] QTR  = ANG_W'(64'sd1073741824);
  localparam logic signed [ANG_W-1:0] HALF = ANG_W'(64'sd2147483648);

  tag_t                     tag_r  [CORDIC_STAGES+1];
  logic                     flip_r [CORDIC_STAGES+1];
  logic signed [TRIG_W-1:0] x_r    [CORDIC_STAGES+1];
  logic signed [TRIG_W-1:0] y_r    [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0]  a_r    [CORDIC_STAGES+1];

  logic signed [ANG_W-1:0] a_raw;
  assign a_raw = ANG_W'($signed({in_phase, 16'd0}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else begin
      tag_r[0] <= in_tag;
    end
    x_r[0] <= INV_GAIN;
    y_r[0] <= '0;
    if (a_raw > QTR) begin
      a_r[0]    <= a_raw - HALF;
      flip_r[0] <= 1'b1;
    end else if (a_raw < -QTR) begin
      a_r[0]    <= a_raw + HALF;
      flip_r[0] <= 1'b1;
    end else begin
      a_r[0]    <= a_raw;
      flip_r[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(atan_turn(i));
    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[i+1] <= '0;
      end else begin
        tag_r[i+1] <= tag_r[i];
      end
      flip_r[i+1] <= flip_r[i];
      if (a_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        a_r[i+1] <= a_r[i] - ATAN;
      end else begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        a_r[i+1] <= a_r[i] + ATAN;
      end
    end
  end

  tag_t                     otag_r;
  logic signed [TRIG_W-1:0] cos_r;
  logic signed [TRIG_W-1:0] sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      otag_r <= '0;
    end else begin
      otag_r <= tag_r[CORDIC_STAGES];
    end
    cos_r <= flip_r[CORDIC_STAGES] ? -x_r[CORDIC_STAGES] : x_r[CORDIC_STAGES];
    sin_r <= flip_r[CORDIC_STAGES] ? -y_r[CORDIC_STAGES] : y_r[CORDIC_STAGES];
  end

  assign out_tag = otag_r;
  assign out_cos = cos_r;
  assign out_sin = sin_r;

endmodule

FILE: hw/rtl/asvg_scale.sv
// Radius scaling: four products in one stage, then rounding and clamping to
// Q1.15 in the next. Depends on asvg_pkg.
module asvg_scale (
  input  logic                               clk,
  input  logic                               rst_n,
  input  asvg_pkg::tag_t                     in_tag,
  input  logic signed [asvg_pkg::TRIG_W-1:0] in_cos,
  input  logic signed [asvg_pkg::TRIG_W-1:0] in_sin,
  input  logic [asvg_pkg::RAD_W-1:0]         outer_rad,
  input  logic [asvg_pkg::RAD_W-1:0]         inner_rad,
  output asvg_pkg::tag_t                     out_tag,
  output asvg_pkg::coord_set_t               out_coords
);
  import asvg_pkg::*;

  localparam int P_W = TRIG_W + RAD_W + 1;
  localparam int R_W = P_W - 30;

  function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] biased;
    logic signed [R_W-1:0] v;
    logic signed [COORD_W-1:0] res;
    biased = p + P_W'(64'sd536870912);
    v      = R_W'(biased >>> 30);
    if (v > R_W'(32768)) begin
      res = COORD_W'(32768);
    end else if (v < -R_W'(32768)) begin
      res = -COORD_W'(32768);
    end else begin
      res = COORD_W'(v);
    end
    return res;
  endfunction

  logic signed [RAD_W:0] ro;
  logic signed [RAD_W:0] ri;
  assign ro = $signed({1'b0, outer_rad});
  assign ri = $signed({1'b0, inner_rad});

  tag_t                  ptag_r;
  logic signed [P_W-1:0] pox_r, poy_r, pix_r, piy_r;
  tag_t                  rtag_r;
  coord_set_t            coords_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptag_r <= '0;
      rtag_r <= '0;
    end else begin
      ptag_r <= in_tag;
      rtag_r <= ptag_r;
    end
    pox_r <= in_cos * ro;
    poy_r <= in_sin * ro;
    pix_r <= in_cos * ri;
    piy_r <= in_sin * ri;
    coords_r.ox <= round_sat(pox_r);
    coords_r.oy <= round_sat(poy_r);
    coords_r.ix <= round_sat(pix_r);
    coords_r.iy <= round_sat(piy_r);
  end

  assign out_tag    = rtag_r;
  assign out_coords = coords_r;

endmodule

FILE: hw/rtl/annulus_sector_vertex_generator.sv
// Annulus sector vertex generator, top level: configuration registers, issue, vertex serialiser.
// Corner 0 of a slice reaches the result ports through the angle, CORDIC and scale
// pipelines and the serialiser; corners 1 to 5 follow back to back.
// Pacing: busy spaces the slices, set by the six vertices sharing one result port.
// Reset (synchronous, rst_n low) empties the pipeline and restores the register defaults.
// The receiver cannot stall: every vertex is shown for exactly one cycle.
module annulus_sector_vertex_generator #(
  parameter int MAX_SLICES    = 256,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [7:0]                          in_slice_index,
  input  logic                                cfg_we,
  input  logic [asvg_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [asvg_pkg::CFG_W-1:0]          cfg_wdata,
  output logic                                out_valid,
  output logic signed [asvg_pkg::COORD_W-1:0] out_vertex_x,
  output logic signed [asvg_pkg::COORD_W-1:0] out_vertex_y,
  output logic [2:0]                          out_corner,
  output logic                                out_last
);
  import asvg_pkg::*;

  // Configuration registers. Writes must arrive only while the block is idle; the block does
  // not enforce this, and the pipeline reads them directly rather than carrying copies along.
  logic [8:0]       subdiv_r;
  logic [RAD_W-1:0] outer_r;
  logic [RAD_W-1:0] inner_r;
  logic [CFG_W-1:0] start_ang_r;
  logic [CFG_W-1:0] end_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subdiv_r    <= 9'd25;
      outer_r     <= RAD_W'(32768);
      inner_r     <= '0;
      start_ang_r <= '0;
      end_ang_r   <= CFG_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SUBDIV: subdiv_r    <= cfg_wdata[8:0];
        REG_OUTER:  outer_r     <= cfg_wdata[RAD_W-1:0];
        REG_INNER:  inner_r     <= cfg_wdata[RAD_W-1:0];
        REG_START:  start_ang_r <= cfg_wdata;
        REG_END:    end_ang_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Issue. A transfer sends angle k = index into the pipeline at once, and
  // k = index + 1 in the following cycle. The spacing counter then holds busy
  // until it counts down to zero, which matches the serialiser's pace.
  logic           accept;
  logic [2:0]     space_r;
  logic [7:0]     idx_r;
  tag_t           iss_tag;
  logic [K_W-1:0] iss_k;

  assign accept = start && !busy;
  assign busy   = space_r != 3'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_r <= '0;
    end else if (accept) begin
      space_r <= 3'd5;
    end else if (busy) begin
      space_r <= space_r - 3'd1;
    end
    if (accept) begin
      idx_r <= in_slice_index;
    end
  end

  assign iss_tag.valid  = accept || (space_r == 3'd5);
  assign iss_tag.second = !accept;
  assign iss_k          = accept ? {1'b0, in_slice_index} : ({1'b0, idx_r} + K_W'(1));

  tag_t                     ang_tag;
  logic [PH_W-1:0]          ang_phase;
  tag_t                     trig_tag;
  logic signed [TRIG_W-1:0] trig_cos;
  logic signed [TRIG_W-1:0] trig_sin;
  tag_t                     sc_tag;
  coord_set_t               sc_coords;

  asvg_angle #(
    .MAX_SLICES(MAX_SLICES)
  ) u_angle (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (iss_tag),
    .in_k     (iss_k),
    .subdiv   (subdiv_r),
    .start_ang(start_ang_r),
    .end_ang  (end_ang_r),
    .out_tag  (ang_tag),
    .out_phase(ang_phase)
  );

  asvg_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (ang_tag),
    .in_phase(ang_phase),
    .out_tag (trig_tag),
    .out_cos (trig_cos),
    .out_sin (trig_sin)
  );

  asvg_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tag    (trig_tag),
    .in_cos    (trig_cos),
    .in_sin    (trig_sin),
    .outer_rad (outer_r),
    .inner_rad (inner_r),
    .out_tag   (sc_tag),
    .out_coords(sc_coords)
  );

  // Serialiser. The first angle's coordinates are held until the second angle
  // arrives in the next cycle; then the slice is loaded and corner 0 goes out.
  // The issue spacing keeps slices far enough apart that a load never meets a
  // burst still in progress.
  coord_set_t                first_r;
  coord_set_t                second_r;
  logic                      emit_r;
  logic [2:0]                corner_r;
  logic                      valid_r;
  logic signed [COORD_W-1:0] vx_r;
  logic signed [COORD_W-1:0] vy_r;
  logic [2:0]                corner_nxt;

  assign corner_nxt = corner_r + 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r  <= 1'b0;
      valid_r <= 1'b0;
    end else if (sc_tag.valid && sc_tag.second) begin
      emit_r  <= 1'b1;
      valid_r <= 1'b1;
    end else if (emit_r) begin
      valid_r <= 1'b1;
      emit_r  <= corner_nxt != 3'd5;
    end else begin
      valid_r <= 1'b0;
    end

    if (sc_tag.valid && !sc_tag.second) begin
      first_r <= sc_coords;
    end

    if (sc_tag.valid && sc_tag.second) begin
      second_r <= sc_coords;
      corner_r <= 3'd0;
      vx_r     <= first_r.ox;
      vy_r     <= first_r.oy;
    end else if (emit_r) begin
      corner_r <= corner_nxt;
      // Corner order: outer1, outer2, inner1, inner1, outer2, inner2.
      case (corner_nxt)
        3'd1, 3'd4: begin
          vx_r <= second_r.ox;
          vy_r <= second_r.oy;
        end
        3'd2, 3'd3: begin
          vx_r <= first_r.ix;
          vy_r <= first_r.iy;
        end
        default: begin
          vx_r <= second_r.ix;
          vy_r <= second_r.iy;
        end
      endcase
    end
  end

  assign out_valid    = valid_r;
  assign out_vertex_x = vx_r;
  assign out_vertex_y = vy_r;
  assign out_corner   = corner_r;
  assign out_last     = valid_r && (corner_r == 3'd5);

  // A transfer always raises busy for the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after a transfer");

  // A six-vertex burst is never broken off early.
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("vertex burst ended before corner five");

  // Within a burst the corner advances by one each cycle.
  a_corner_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> (out_corner == $past(out_corner) + 3'd1))
    else $error("corner sequence broken");

  // The second angle of a slice directly follows the first through the pipeline.
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (sc_tag.valid && !sc_tag.second) |=> (sc_tag.valid && sc_tag.second))
    else $error("angle pair split in the pipeline");

endmodule

FILE: dv/annulus_sector_vertex_generator_tb.sv
// Self-checking testbench for the annulus sector vertex generator.
// Depends on asvg_pkg and annulus_sector_vertex_generator; predicts every vertex on its own.
`timescale 1ns / 100ps

module annulus_sector_vertex_generator_tb;
  import asvg_pkg::*;

  localparam int STAGES     = 16;
  localparam int SLICE_CAP  = 256;
  localparam int LATENCY    = 32 + STAGES + 6;
  localparam int CYCLE_CAP  = 400000;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [2:0]         corner;
    logic               last;
  } vertex_t;

  // The scoreboard keeps its own copy of the registers and a queue of the
  // vertices still owed by the block, oldest first.
  class vertex_scoreboard;
    longint  slice_count, outer_r, inner_r, start_ang, end_ang;
    vertex_t owed[$];
    int      errors;
    int      slices_seen;
    int      vertices_seen;
    longint  atan_tab[16];

    function new();
      atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                   10679838, 5340245, 2670163, 1335087, 667544, 333772,
                   166886, 83443, 41722, 20861};
      reset_regs();
      errors = 0;
      slices_seen = 0;
      vertices_seen = 0;
    endfunction

    function void reset_regs();
      slice_count = 25;
      outer_r = 32768;
      inner_r = 0;
      start_ang = 0;
      end_ang = 65536;
    endfunction

    function void note_write(cfg_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_SUBDIV: slice_count = val[8:0];
        REG_OUTER:  outer_r = val[15:0];
        REG_INNER:  inner_r = val[15:0];
        REG_START:  start_ang = val;
        REG_END:    end_ang = val;
        default: ;
      endcase
    endfunction

    // Phase of angle k, truncating the quotient toward zero, wrapped to one turn.
    function longint phase_of(longint k, longint cnt);
      longint q;
      q = (k * (end_ang - start_ang)) / cnt;
      return (start_ang + q) & 64'hFFFF;
    endfunction

    function void rotate(longint ph, output longint c, output longint s);
      longint a, x, y, dx, dy;
      bit flip;
      a = ph << 16;
      flip = 0;
      x = 652032874;
      y = 0;
      if (a >= 64'sd2147483648) a -= 64'sd4294967296;
      if (a > 64'sd1073741824) begin
        a -= 64'sd2147483648;
        flip = 1;
      end else if (a < -64'sd1073741824) begin
        a += 64'sd2147483648;
        flip = 1;
      end
      for (int i = 0; i < STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (a >= 0) begin
          x -= dx;
          y += dy;
          a -= atan_tab[i];
        end else begin
          x += dx;
          y -= dy;
          a += atan_tab[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function logic [COORD_W-1:0] scale(longint trig, longint radius);
      longint v;
      v = (trig * radius + 64'sd536870912) >>> 30;
      if (v > 32768) v = 32768;
      if (v < -32768) v = -32768;
      return v[COORD_W-1:0];
    endfunction

    // An accepted transfer owes six vertices: outer1, outer2, inner1, inner1, outer2, inner2.
    function void note_slice(logic [7:0] idx);
      longint cnt, c1, s1, c2, s2;
      logic [COORD_W-1:0] px[6], py[6];
      vertex_t v;
      cnt = slice_count;
      if (cnt < 1) cnt = 1;
      if (cnt > SLICE_CAP) cnt = SLICE_CAP;
      rotate(phase_of(idx, cnt), c1, s1);
      rotate(phase_of(longint'(idx) + 1, cnt), c2, s2);
      px[0] = scale(c1, outer_r); py[0] = scale(s1, outer_r);
      px[1] = scale(c2, outer_r); py[1] = scale(s2, outer_r);
      px[2] = scale(c1, inner_r); py[2] = scale(s1, inner_r);
      px[3] = px[2];              py[3] = py[2];
      px[4] = px[1];              py[4] = py[1];
      px[5] = scale(c2, inner_r); py[5] = scale(s2, inner_r);
      for (int k = 0; k < 6; k++) begin
        v.x = px[k];
        v.y = py[k];
        v.corner = k[2:0];
        v.last = (k == 5);
        owed.push_back(v);
      end
      slices_seen++;
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t want;
      vertices_seen++;
      if (owed.size() == 0) begin
        $error("vertex with nothing owed: x=%0d y=%0d corner=%0d",
               $signed(got.x), $signed(got.y), got.corner);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.x !== want.x) begin
        $error("vertex_x: expected %0d, got %0d", $signed(want.x), $signed(got.x));
        errors++;
      end
      if (got.y !== want.y) begin
        $error("vertex_y: expected %0d, got %0d", $signed(want.y), $signed(got.y));
        errors++;
      end
      if (got.corner !== want.corner) begin
        $error("corner: expected %0d, got %0d", want.corner, got.corner);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [7:0]         in_slice_index;
  logic               cfg_we;
  logic [CIDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;
  logic               out_valid;
  logic signed [COORD_W-1:0] out_vertex_x;
  logic signed [COORD_W-1:0] out_vertex_y;
  logic [2:0]         out_corner;
  logic               out_last;

  vertex_scoreboard sb;
  int unsigned      cycles;

  annulus_sector_vertex_generator #(
    .MAX_SLICES(SLICE_CAP),
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_slice_index(in_slice_index),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_vertex_x(out_vertex_x),
    .out_vertex_y(out_vertex_y),
    .out_corner(out_corner),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Everything the block does is observed at the rising edge: an accepted input
  // transfer creates six owed vertices, and every strobed vertex is checked at once.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_slice(in_slice_index);
      if (out_valid) sb.check_vertex({out_vertex_x, out_vertex_y, out_corner, out_last});
    end
  end

  // A hung block must not hang the run: the cycle counter ends it.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // Writes are only issued while nothing is owed, so the block is idle.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.note_write(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Slice index for the current setting: mostly within the slice count, the
  // rest anywhere in the field so that indices past the count are exercised.
  function automatic logic [7:0] pick_index();
    int cnt;
    cnt = int'((sb.slice_count < 1) ? 1 : (sb.slice_count > 256 ? 256 : sb.slice_count));
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, cnt - 1));
  endfunction

  // Sends a list of slice indices. With gaps set, a random idle gap is drawn before
  // each transfer; a zero gap keeps start high so back-to-back transfers are tried.
  task automatic send_slices(logic [7:0] items[$], bit gaps);
    int gap;
    @(negedge clk);
    for (int n = 0; n < items.size(); n++) begin
      gap = gaps ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk);
      end
      start = 1'b1;
      in_slice_index = items[n];
      do @(posedge clk); while (busy);
      @(negedge clk);
    end
    start = 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_angle();
    case ($urandom_range(0, 4))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      default: return 17'($urandom_range(0, 131071));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_radius();
    case ($urandom_range(0, 4))
      0: return 17'd0;
      1: return 17'd32768;
      2: return 17'hFFFF;
      default: return 17'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_count();
    case ($urandom_range(0, 6))
      0: return 17'd0;
      1: return 17'd1;
      2: return 17'd256;
      3: return 17'd511;
      4: return 17'($urandom_range(257, 511));
      default: return 17'($urandom_range(1, 256));
    endcase
  endfunction

  initial begin
    logic [7:0] items[$];
    sb = new();
    cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_slice_index = '0;
    cfg_we = 1'b0;
    cfg_index = REG_SUBDIV;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: the reset setting, with indices at the ends and past the count.
    items = '{8'd0, 8'd1, 8'd24, 8'd25, 8'd26, 8'd128, 8'd254, 8'd255};
    send_slices(items, 1'b0);
    drain();

    // Directed: a zero count (treated as one), full radii, a reversed sector.
    write_reg(REG_SUBDIV, 17'd0);
    write_reg(REG_OUTER, 17'hFFFF);
    write_reg(REG_INNER, 17'd32768);
    write_reg(REG_START, 17'h1FFFF);
    write_reg(REG_END, 17'd0);
    items = '{8'd0, 8'd1, 8'd255, 8'd170, 8'd85};
    send_slices(items, 1'b1);
    drain();

    // Directed: a count above the slice limit, a zero outer radius, the largest inner radius, equal angles.
    write_reg(REG_SUBDIV, 17'd511);
    write_reg(REG_OUTER, 17'd0);
    write_reg(REG_INNER, 17'hFFFF);
    write_reg(REG_START, 17'd65536);
    write_reg(REG_END, 17'd65536);
    items = '{8'd0, 8'd255, 8'd127};
    send_slices(items, 1'b0);
    drain();

    // Directed: 256 slices over a full turn, every quadrant boundary.
    write_reg(REG_SUBDIV, 17'd256);
    write_reg(REG_OUTER, 17'd32768);
    write_reg(REG_INNER, 17'd16384);
    write_reg(REG_START, 17'd0);
    write_reg(REG_END, 17'd65536);
    items = '{8'd63, 8'd64, 8'd127, 8'd128, 8'd191, 8'd192, 8'd255};
    send_slices(items, 1'b1);
    drain();

    // Random: a fresh setting per phase, random indices, and random gaps in all but every fourth phase.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_SUBDIV, pick_count());
      write_reg(REG_OUTER, pick_radius());
      write_reg(REG_INNER, pick_radius());
      write_reg(REG_START, pick_angle());
      write_reg(REG_END, pick_angle());
      items.delete();
      for (int n = 0; n < 46; n++) items.push_back(pick_index());
      send_slices(items, (ph % 4) != 3);
      drain();
    end

    $display("covered %0d slices and %0d vertices over 14 register settings",
             sb.slices_seen, sb.vertices_seen);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
